>>> hw/rtl/view_frustum_cull_test_defines.svh
// Assertion macros shared by the view frustum cull checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef VIEW_FRUSTUM_CULL_TEST_DEFINES_SVH
`define VIEW_FRUSTUM_CULL_TEST_DEFINES_SVH

// same-cycle implication
`define VFCT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VFCT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/vfct_pkg.sv
// Shared types, constants and helpers for the view frustum cull test.
// No dependencies.
package vfct_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int PLANE_COUNT     = 6;
   localparam int COEF_WIDTH      = 16;
   localparam int D_SHIFT         = 14;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [COEF_WIDTH-1:0] SPHERE_SCALE = COEF_WIDTH'(1 << D_SHIFT);

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_SPHERE = 2'd1,
      OP_CUBE   = 2'd2,
      OP_BOX    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] a;
      logic signed [COEF_WIDTH-1:0] b;
      logic signed [COEF_WIDTH-1:0] c;
      logic signed [COEF_WIDTH-1:0] d;
   } plane_type;

   typedef struct packed {
      logic       load;
      opcode_type opcode;
   } plane_ctl_type;

   function automatic logic [COEF_WIDTH-1:0] coef_abs(logic signed [COEF_WIDTH-1:0] v);
      return v[COEF_WIDTH-1] ? COEF_WIDTH'(-v) : COEF_WIDTH'(v);
   endfunction

endpackage

>>> hw/rtl/vfct_req_if.sv
// Request channel carrying one object to test.
// Depends on vfct_pkg.
interface vfct_req_if #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic signed [COORD_WIDTH-1:0] center_z;
   logic [COORD_WIDTH-2:0]        extent_x;
   logic [COORD_WIDTH-2:0]        extent_y;
   logic [COORD_WIDTH-2:0]        extent_z;

   modport source (
      output valid, opcode, center_x, center_y, center_z,
             extent_x, extent_y, extent_z,
      input  ready
   );

   modport sink (
      input  valid, opcode, center_x, center_y, center_z,
             extent_x, extent_y, extent_z,
      output ready
   );
endinterface

>>> hw/rtl/vfct_rsp_if.sv
// Response channel carrying the visibility verdict.
// No dependencies.
interface vfct_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

>>> hw/rtl/vfct_csr_if.sv
// Register write channel for the frustum planes.
// Depends on vfct_pkg.
interface vfct_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [vfct_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [vfct_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/vfct_plane_eval.sv
// One frustum plane: registered products, then the signed sum and its sign.
// Depends on vfct_pkg.
module vfct_plane_eval #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  vfct_pkg::plane_type           plane,
   input  vfct_pkg::plane_ctl_type       ctl,
   input  logic signed [COORD_WIDTH-1:0] center_x,
   input  logic signed [COORD_WIDTH-1:0] center_y,
   input  logic signed [COORD_WIDTH-1:0] center_z,
   input  logic [COORD_WIDTH-2:0]        extent_x,
   input  logic [COORD_WIDTH-2:0]        extent_y,
   input  logic [COORD_WIDTH-2:0]        extent_z,
   output logic                          culled
);

   localparam int CPW = COORD_WIDTH + vfct_pkg::COEF_WIDTH;
   localparam int BPW = CPW - 1;
   localparam int SW  = COORD_WIDTH + 24;

   logic [vfct_pkg::COEF_WIDTH-1:0] k0;
   logic [vfct_pkg::COEF_WIDTH-1:0] k1;
   logic [vfct_pkg::COEF_WIDTH-1:0] k2;
   logic [COORD_WIDTH-2:0]          e0;
   logic [COORD_WIDTH-2:0]          e1;
   logic [COORD_WIDTH-2:0]          e2;

   logic signed [CPW-1:0] prod_ax_in, prod_ax_ff;
   logic signed [CPW-1:0] prod_by_in, prod_by_ff;
   logic signed [CPW-1:0] prod_cz_in, prod_cz_ff;
   logic [BPW-1:0]        bias0_in, bias0_ff;
   logic [BPW-1:0]        bias1_in, bias1_ff;
   logic [BPW-1:0]        bias2_in, bias2_ff;

   logic signed [SW-1:0] term_d;
   logic signed [SW-1:0] total;

   always_comb begin
      k0 = '0;
      k1 = '0;
      k2 = '0;
      e0 = '0;
      e1 = '0;
      e2 = '0;
      unique case (ctl.opcode)
         vfct_pkg::OP_POINT: begin
         end
         vfct_pkg::OP_SPHERE: begin
            k0 = vfct_pkg::SPHERE_SCALE;
            e0 = extent_x;
         end
         vfct_pkg::OP_CUBE: begin
            k0 = vfct_pkg::coef_abs(plane.a);
            k1 = vfct_pkg::coef_abs(plane.b);
            k2 = vfct_pkg::coef_abs(plane.c);
            e0 = extent_x;
            e1 = extent_x;
            e2 = extent_x;
         end
         vfct_pkg::OP_BOX: begin
            k0 = vfct_pkg::coef_abs(plane.a);
            k1 = vfct_pkg::coef_abs(plane.b);
            k2 = vfct_pkg::coef_abs(plane.c);
            e0 = extent_x;
            e1 = extent_y;
            e2 = extent_z;
         end
         default: begin
         end
      endcase
   end

   // worst corner is the center value plus the sum of |coef| times half size
   assign prod_ax_in = CPW'(plane.a) * CPW'(center_x);
   assign prod_by_in = CPW'(plane.b) * CPW'(center_y);
   assign prod_cz_in = CPW'(plane.c) * CPW'(center_z);
   assign bias0_in   = BPW'(k0) * BPW'(e0);
   assign bias1_in   = BPW'(k1) * BPW'(e1);
   assign bias2_in   = BPW'(k2) * BPW'(e2);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ax_ff <= prod_ax_in;
         prod_by_ff <= prod_by_in;
         prod_cz_ff <= prod_cz_in;
         bias0_ff   <= bias0_in;
         bias1_ff   <= bias1_in;
         bias2_ff   <= bias2_in;
      end
   end

   assign term_d = SW'(plane.d) <<< vfct_pkg::D_SHIFT;

   assign total = SW'(prod_ax_ff) + SW'(prod_by_ff) + SW'(prod_cz_ff) + term_d
                + SW'(bias0_ff) + SW'(bias1_ff) + SW'(bias2_ff);

   assign culled = total[SW-1];

endmodule

>>> hw/rtl/view_frustum_cull_test.sv
// View frustum cull test: top level with plane registers and handshake pipeline.
// Depends on vfct_pkg, vfct_req_if, vfct_rsp_if, vfct_csr_if, vfct_plane_eval.

// Tests a point, sphere, cube or box against six frustum planes and returns
// visible = 1 unless some plane rejects the object. One transaction is
// accepted per clock cycle while the response side is ready; the verdict
// passes through the input register, product register and result register,
// and all six planes are evaluated in parallel by their own multipliers.
// Planes reset to zero, which makes every object visible. They must be
// written through the csr port while no transaction is in flight; the block
// does not enforce this. Indexes past the bottom plane are ignored.
module view_frustum_cull_test #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   vfct_req_if.sink   req_if,
   vfct_rsp_if.source rsp_if,
   vfct_csr_if.sink   csr_if
);

   localparam int PC = vfct_pkg::PLANE_COUNT;

   vfct_pkg::plane_type plane_ff [PC];

   logic                          s1_valid_in, s1_valid_ff;
   vfct_pkg::opcode_type          s1_opcode_ff;
   logic signed [COORD_WIDTH-1:0] s1_cx_ff;
   logic signed [COORD_WIDTH-1:0] s1_cy_ff;
   logic signed [COORD_WIDTH-1:0] s1_cz_ff;
   logic [COORD_WIDTH-2:0]        s1_ex_ff;
   logic [COORD_WIDTH-2:0]        s1_ey_ff;
   logic [COORD_WIDTH-2:0]        s1_ez_ff;

   logic s2_valid_in, s2_valid_ff;
   logic rsp_valid_in, rsp_valid_ff;
   logic visible_in, visible_ff;

   logic req_fire;
   logic s2_ready;
   logic s2_load;
   logic out_ready;
   logic out_load;

   vfct_pkg::plane_ctl_type ctl;
   logic [PC-1:0]           culled;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PC; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < PC; i++) begin
            if (csr_if.valid && csr_if.index == vfct_pkg::CSR_INDEX_WIDTH'(i)) begin
               plane_ff[i] <= vfct_pkg::plane_type'(csr_if.data);
            end
         end
      end
   end

   assign out_ready    = !rsp_valid_ff || rsp_if.ready;
   assign s2_ready     = !s2_valid_ff || out_ready;
   assign req_if.ready = !s1_valid_ff || s2_ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign s2_load      = s1_valid_ff && s2_ready;
   assign out_load     = s2_valid_ff && out_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s2_ready);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !out_ready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff <= vfct_pkg::opcode_type'(req_if.opcode);
         s1_cx_ff     <= req_if.center_x;
         s1_cy_ff     <= req_if.center_y;
         s1_cz_ff     <= req_if.center_z;
         s1_ex_ff     <= req_if.extent_x;
         s1_ey_ff     <= req_if.extent_y;
         s1_ez_ff     <= req_if.extent_z;
      end
   end

   assign ctl.load   = s2_load;
   assign ctl.opcode = s1_opcode_ff;

   for (genvar p = 0; p < PC; p++) begin : g_plane
      vfct_plane_eval #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_plane (
         .clock    (clock),
         .plane    (plane_ff[p]),
         .ctl      (ctl),
         .center_x (s1_cx_ff),
         .center_y (s1_cy_ff),
         .center_z (s1_cz_ff),
         .extent_x (s1_ex_ff),
         .extent_y (s1_ey_ff),
         .extent_z (s1_ez_ff),
         .culled   (culled[p])
      );
   end

   assign visible_in = ~|culled;

   always_ff @(posedge clock) begin
      if (out_load) begin
         visible_ff <= visible_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.visible = visible_ff;

endmodule

>>> hw/rtl/vfct_checker.sv
// Port-level checks for the view frustum cull test, bound to the top level.
// Depends on view_frustum_cull_test_defines.svh and view_frustum_cull_test.
`include "view_frustum_cull_test_defines.svh"

module vfct_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible
);

   `VFCT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_visible), "response changed while stalled")

   `VFCT_ASSERT_IMP(a_req_open, !rsp_valid || rsp_ready, req_ready, "request blocked with free output")

   `VFCT_ASSERT_NXT(a_latency, (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready, rsp_valid, "transaction missing after two free cycles")

endmodule

bind view_frustum_cull_test vfct_checker u_vfct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_visible (rsp_if.visible)
);
